@@ rtl/core/wrs_pkg.sv @@
package wrs_pkg;

  // digit width of the shared multiplier's wide operand
  localparam int unsigned DIG_W = 16;

  // Q1.15 rounding: add half, shift right
  localparam int unsigned RND_SHIFT = 15;

  localparam logic [16:0] ALPHA_ONE   = 17'd32768;
  localparam logic [15:0] ALPHA_RESET = 16'd16384;

  // item kinds carried on in_tuser
  localparam logic [1:0] FN_FWD = 2'd0;
  localparam logic [1:0] FN_BWD = 2'd1;
  localparam logic [1:0] FN_CLR = 2'd2;

  // skip modes
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_MIX  = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_BUSY,
    ST_OUT
  } state_t;

  // products of a mixed-mode item, in issue order
  typedef enum logic [2:0] {
    OP_FA,  // F * alpha
    OP_XB,  // x * beta, added to F * alpha
    OP_GA,  // dout * alpha
    OP_GB,  // dout * beta
    OP_GD,  // dout * (F - x)
    OP_SA,  // run_sum * alpha
    OP_TB   // rounded run_sum * alpha, times beta
  } op_t;

  typedef struct packed {
    logic start;  // latch operands and begin a product
    logic accum;  // add onto the previous product instead of replacing it
    logic wide;   // wide operand spans the accumulator width
  } mac_cmd_t;

endpackage

@@ rtl/core/weighted_residual_skip_core.sv @@
// Pass, add, clear and undefined items go from acceptance to the output state, which loads the
// result register once the output is free. Mixed items run their products one after another on
// the shared multiplier (two products forward, three backward, each waiting for its done), with
// two more wide end-of-run products on a last backward element, before the output state.
// Items are taken one at a time; the next word is taken in the cycle after the result loads.
// Reset (rst_n low, synchronous): mode 0, alpha 0.5, run sum and gradient cleared, no result.
module weighted_residual_skip_core #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_tvalid,
  output logic                                               in_tready,
  // module_val, input_val, grad_val
  input  logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0]        in_tdata,
  // func
  input  logic [1:0]                                         in_tuser,
  input  logic                                               in_tlast,
  output logic                                               out_tvalid,
  input  logic                                               out_tready,
  // out_a, out_b, grad_total
  output logic [((2 * DATA_WIDTH + ACC_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                                               cfg_valid,
  output logic                                               cfg_ready,
  input  logic                                               cfg_index,
  input  logic [15:0]                                        cfg_data
);

  localparam int BW    = (DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17;
  localparam int PW    = ACC_WIDTH + BW + 1;
  localparam int OUT_W = ((2 * DATA_WIDTH + ACC_WIDTH + 7) / 8) * 8;

  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] alpha_r, alpha_nxt;

  logic [16:0]          a_clamp;
  logic signed [BW-1:0] a_val;
  logic signed [BW-1:0] b_val;

  wrs_pkg::mac_cmd_t           mac_cmd;
  logic signed [ACC_WIDTH-1:0] mac_a;
  logic signed [BW-1:0]        mac_b;
  logic                        mac_done;
  logic signed [PW-1:0]        mac_acc;

  logic signed [DATA_WIDTH-1:0] out_a;
  logic signed [DATA_WIDTH-1:0] out_b;
  logic signed [ACC_WIDTH-1:0]  out_grad;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    alpha_nxt = alpha_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        wrs_pkg::REG_MODE:  mode_nxt  = cfg_data[1:0];
        wrs_pkg::REG_ALPHA: alpha_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= wrs_pkg::MODE_PASS;
      alpha_r <= wrs_pkg::ALPHA_RESET;
    end else begin
      mode_r  <= mode_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  // alpha above one counts as one; beta is the complement
  always_comb begin
    a_clamp = ({1'b0, alpha_r} > wrs_pkg::ALPHA_ONE) ? wrs_pkg::ALPHA_ONE : {1'b0, alpha_r};
    a_val   = BW'(a_clamp);
    b_val   = BW'(wrs_pkg::ALPHA_ONE - a_clamp);
  end

  wrs_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .in_f       (in_tdata[DATA_WIDTH-1:0]),
    .in_x       (in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .in_g       (in_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
    .in_last    (in_tlast),
    .mode       (mode_r),
    .a_val      (a_val),
    .b_val      (b_val),
    .mac_cmd    (mac_cmd),
    .mac_a      (mac_a),
    .mac_b      (mac_b),
    .mac_done   (mac_done),
    .mac_acc    (mac_acc),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_a      (out_a),
    .out_b      (out_b),
    .out_grad   (out_grad)
  );

  wrs_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .a_op  (mac_a),
    .b_op  (mac_b),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  assign out_tdata = OUT_W'({out_grad, out_b, out_a});

endmodule

@@ rtl/core/wrs_mac.sv @@
module wrs_mac #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  wrs_pkg::mac_cmd_t                                   cmd,
  input  logic signed [ACC_WIDTH-1:0]                         a_op,
  input  logic signed [((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17)-1:0] b_op,
  output logic                                                done,
  output logic signed [ACC_WIDTH + ((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17):0] acc
);

  localparam int DIG = wrs_pkg::DIG_W;
  localparam int BW  = (DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17;
  localparam int PW  = ACC_WIDTH + BW + 1;
  localparam int ND  = (ACC_WIDTH + DIG - 1) / DIG;
  localparam int NDD = (DATA_WIDTH + DIG - 1) / DIG;
  localparam int AW  = ND * DIG;
  localparam int KW  = (ND > 1) ? $clog2(ND) : 1;

  logic signed [AW-1:0]  a_r, a_nxt;
  logic signed [BW-1:0]  b_r, b_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [KW-1:0]         top_r, top_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;

  logic [DIG-1:0]           digit;
  logic signed [DIG:0]      dig_s;
  logic signed [DIG+BW:0]   prod;
  logic signed [PW-1:0]     prod_sh;

  // low digits are unsigned, the top digit carries the sign
  always_comb begin
    digit   = a_r[k_r*DIG +: DIG];
    dig_s   = (k_r == top_r) ? {digit[DIG-1], digit} : {1'b0, digit};
    prod    = dig_s * b_r;
    prod_sh = PW'(prod) <<< (32'(k_r) * DIG);
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    top_nxt  = top_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (cmd.start) begin
      a_nxt    = AW'(a_op);
      b_nxt    = b_op;
      k_nxt    = '0;
      top_nxt  = cmd.wide ? KW'(ND - 1) : KW'(NDD - 1);
      busy_nxt = 1'b1;
      if (!cmd.accum) begin
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      acc_nxt = acc_r + prod_sh;
      if (k_r == top_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    top_r <= top_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("product started while the multiplier is busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held for more than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a product in flight");

endmodule

@@ rtl/core/wrs_ctrl.sv @@
module wrs_ctrl #(
  parameter int DATA_WIDTH = 16,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  // input words
  input  logic                                                in_tvalid,
  output logic                                                in_tready,
  input  logic [1:0]                                          in_func,
  input  logic signed [DATA_WIDTH-1:0]                        in_f,
  input  logic signed [DATA_WIDTH-1:0]                        in_x,
  input  logic signed [DATA_WIDTH-1:0]                        in_g,
  input  logic                                                in_last,
  // configuration
  input  logic [1:0]                                          mode,
  input  logic signed [((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17)-1:0] a_val,
  input  logic signed [((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17)-1:0] b_val,
  // shared multiplier
  output wrs_pkg::mac_cmd_t                                   mac_cmd,
  output logic signed [ACC_WIDTH-1:0]                         mac_a,
  output logic signed [((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17)-1:0] mac_b,
  input  logic                                                mac_done,
  input  logic signed [ACC_WIDTH + ((DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17):0] mac_acc,
  // result words
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  output logic signed [DATA_WIDTH-1:0]                        out_a,
  output logic signed [DATA_WIDTH-1:0]                        out_b,
  output logic signed [ACC_WIDTH-1:0]                         out_grad
);

  localparam int BW = (DATA_WIDTH + 1 > 17) ? DATA_WIDTH + 1 : 17;
  localparam int PW = ACC_WIDTH + BW + 1;

  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (wrs_pkg::RND_SHIFT - 1);
  localparam logic signed [PW-1:0] DMAX =
    {{(PW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [PW-1:0] DMIN = ~DMAX;
  localparam logic signed [PW:0] AMAX =
    {{(PW - ACC_WIDTH + 2){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [PW:0] AMIN = ~AMAX;

  function automatic logic signed [PW-1:0] rnd15(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + RND_HALF;
    return t >>> wrs_pkg::RND_SHIFT;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
    input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = (v > DMAX) ? DMAX : ((v < DMIN) ? DMIN : v);
    return c[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [ACC_WIDTH-1:0] sat_acc_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [PW-1:0] b);
    logic signed [PW:0] s;
    logic signed [PW:0] c;
    s = (PW+1)'(a) + (PW+1)'(b);
    c = (s > AMAX) ? AMAX : ((s < AMIN) ? AMIN : s);
    return c[ACC_WIDTH-1:0];
  endfunction

  wrs_pkg::state_t state_r, state_nxt;
  wrs_pkg::op_t    op_r, op_nxt;

  logic signed [DATA_WIDTH-1:0] f_r, f_nxt;
  logic signed [DATA_WIDTH-1:0] x_r, x_nxt;
  logic signed [DATA_WIDTH-1:0] g_r, g_nxt;
  logic                         last_r, last_nxt;
  logic signed [DATA_WIDTH-1:0] ra_r, ra_nxt;
  logic signed [DATA_WIDTH-1:0] rb_r, rb_nxt;
  logic signed [ACC_WIDTH-1:0]  t1_r, t1_nxt;
  logic signed [ACC_WIDTH-1:0]  run_sum_r, run_sum_nxt;
  logic signed [ACC_WIDTH-1:0]  grad_acc_r, grad_acc_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic signed [DATA_WIDTH-1:0] out_a_r, out_a_nxt;
  logic signed [DATA_WIDTH-1:0] out_b_r, out_b_nxt;
  logic signed [ACC_WIDTH-1:0]  out_grad_r, out_grad_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic                 item_mix;
  logic                 op_final;
  logic signed [PW-1:0] rnd_v;
  logic signed [BW-1:0] fx_diff;
  logic signed [DATA_WIDTH:0] fx_sum;

  assign out_free = !out_tvalid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign item_mix = (mode == wrs_pkg::MODE_MIX) &&
                    ((in_func == wrs_pkg::FN_FWD) || (in_func == wrs_pkg::FN_BWD));
  assign op_final = (op_r == wrs_pkg::OP_XB) || (op_r == wrs_pkg::OP_TB) ||
                    ((op_r == wrs_pkg::OP_GD) && !last_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wrs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = item_mix ? wrs_pkg::ST_ISSUE : wrs_pkg::ST_OUT;
        end
      end
      wrs_pkg::ST_ISSUE: state_nxt = wrs_pkg::ST_BUSY;
      wrs_pkg::ST_BUSY: begin
        if (mac_done) begin
          state_nxt = op_final ? wrs_pkg::ST_OUT : wrs_pkg::ST_ISSUE;
        end
      end
      wrs_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = wrs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wrs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready     = 1'b0;
    mac_cmd.start = 1'b0;
    mac_cmd.accum = (op_r == wrs_pkg::OP_XB);
    mac_cmd.wide  = (op_r == wrs_pkg::OP_SA) || (op_r == wrs_pkg::OP_TB);
    out_load      = 1'b0;
    unique case (state_r)
      wrs_pkg::ST_IDLE:  in_tready = 1'b1;
      wrs_pkg::ST_ISSUE: mac_cmd.start = 1'b1;
      wrs_pkg::ST_BUSY:  ;
      wrs_pkg::ST_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    fx_diff = BW'(f_r) - BW'(x_r);
    mac_a   = ACC_WIDTH'(g_r);
    mac_b   = a_val;
    case (op_r)
      wrs_pkg::OP_FA: begin
        mac_a = ACC_WIDTH'(f_r);
        mac_b = a_val;
      end
      wrs_pkg::OP_XB: begin
        mac_a = ACC_WIDTH'(x_r);
        mac_b = b_val;
      end
      wrs_pkg::OP_GA: mac_b = a_val;
      wrs_pkg::OP_GB: mac_b = b_val;
      wrs_pkg::OP_GD: mac_b = fx_diff;
      wrs_pkg::OP_SA: begin
        mac_a = run_sum_r;
        mac_b = a_val;
      end
      wrs_pkg::OP_TB: begin
        mac_a = t1_r;
        mac_b = b_val;
      end
      default: ;
    endcase
  end

  always_comb begin
    f_nxt          = f_r;
    x_nxt          = x_r;
    g_nxt          = g_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    t1_nxt         = t1_r;
    run_sum_nxt    = run_sum_r;
    grad_acc_nxt   = grad_acc_r;
    out_a_nxt      = out_a_r;
    out_b_nxt      = out_b_r;
    out_grad_nxt   = out_grad_r;
    out_tvalid_nxt = out_tvalid_r;
    rnd_v          = rnd15(mac_acc);
    fx_sum         = (DATA_WIDTH+1)'(in_f) + (DATA_WIDTH+1)'(in_x);

    if (accept) begin
      f_nxt    = in_f;
      x_nxt    = in_x;
      g_nxt    = in_g;
      last_nxt = in_last;
      ra_nxt   = '0;
      rb_nxt   = '0;
      case (in_func)
        wrs_pkg::FN_FWD: begin
          case (mode)
            wrs_pkg::MODE_PASS: ra_nxt = in_f;
            wrs_pkg::MODE_ADD:  ra_nxt = sat_data(PW'(fx_sum));
            wrs_pkg::MODE_MIX:  op_nxt = wrs_pkg::OP_FA;
            default: ;
          endcase
        end
        wrs_pkg::FN_BWD: begin
          case (mode)
            wrs_pkg::MODE_PASS: ra_nxt = in_g;
            wrs_pkg::MODE_ADD: begin
              ra_nxt = in_g;
              rb_nxt = in_g;
            end
            wrs_pkg::MODE_MIX: op_nxt = wrs_pkg::OP_GA;
            default: ;
          endcase
          // mixed mode drops run_sum after the end-of-run update instead
          if (in_last && (mode != wrs_pkg::MODE_MIX)) begin
            run_sum_nxt = '0;
          end
        end
        wrs_pkg::FN_CLR: begin
          grad_acc_nxt = '0;
          run_sum_nxt  = '0;
        end
        default: ;
      endcase
    end

    if ((state_r == wrs_pkg::ST_BUSY) && mac_done) begin
      case (op_r)
        wrs_pkg::OP_FA: op_nxt = wrs_pkg::OP_XB;
        wrs_pkg::OP_XB: ra_nxt = sat_data(rnd_v);
        wrs_pkg::OP_GA: begin
          ra_nxt = sat_data(rnd_v);
          op_nxt = wrs_pkg::OP_GB;
        end
        wrs_pkg::OP_GB: begin
          rb_nxt = sat_data(rnd_v);
          op_nxt = wrs_pkg::OP_GD;
        end
        wrs_pkg::OP_GD: begin
          run_sum_nxt = sat_acc_add(run_sum_r, mac_acc);
          op_nxt      = wrs_pkg::OP_SA;
        end
        wrs_pkg::OP_SA: begin
          t1_nxt = rnd_v[ACC_WIDTH-1:0];
          op_nxt = wrs_pkg::OP_TB;
        end
        wrs_pkg::OP_TB: begin
          grad_acc_nxt = sat_acc_add(grad_acc_r, rnd_v);
          run_sum_nxt  = '0;
        end
        default: ;
      endcase
    end

    if (out_load) begin
      out_a_nxt      = ra_r;
      out_b_nxt      = rb_r;
      out_grad_nxt   = grad_acc_r;
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wrs_pkg::ST_IDLE;
      op_r         <= wrs_pkg::OP_FA;
      run_sum_r    <= '0;
      grad_acc_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      run_sum_r    <= run_sum_nxt;
      grad_acc_r   <= grad_acc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    f_r        <= f_nxt;
    x_r        <= x_nxt;
    g_r        <= g_nxt;
    last_r     <= last_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    t1_r       <= t1_nxt;
    out_a_r    <= out_a_nxt;
    out_b_r    <= out_b_nxt;
    out_grad_r <= out_grad_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_grad   = out_grad_r;

  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == wrs_pkg::ST_BUSY))
    else $error("product finished outside the busy state");

  a_grad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == wrs_pkg::ST_IDLE) && !(in_tvalid && (in_func == wrs_pkg::FN_CLR)))
      |=> $stable(grad_acc_r))
    else $error("gradient register moved while idle");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == wrs_pkg::ST_BUSY) && mac_done && (op_r == wrs_pkg::OP_TB))
      |=> (run_sum_r == '0))
    else $error("run sum kept after end of run");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("loaded result not presented");

endmodule

@@ sim/skip_result_checker.sv @@
module skip_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          open_results
);

  localparam longint ACC_MAX = (64'sd1 <<< 47) - 64'sd1;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;

  // packed from the top down: out_a sits in the lowest bits of the word
  typedef struct packed {
    logic [47:0] grad_total;
    logic [15:0] out_b;
    logic [15:0] out_a;
  } skip_out_t;

  skip_out_t   expected_outs[$];
  logic [1:0]  mode_q;
  logic [15:0] alpha_q;
  longint      run_sum_q;
  longint      grad_acc_q;

  function automatic longint round_q15(longint p);
    return (p + 64'sd16384) >>> wrs_pkg::RND_SHIFT;
  endfunction

  function automatic longint clamp_q88(longint v);
    if (v > 64'sd32767) return 64'sd32767;
    if (v < -64'sd32768) return -64'sd32768;
    return v;
  endfunction

  function automatic longint acc_add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  // Advance the skip state by one element and return the word it yields.
  function automatic skip_out_t predict_skip(input logic [1:0] fn,
                                             input logic signed [15:0] f,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] g,
                                             input logic last);
    longint    f_l, x_l, g_l, a_w, b_w, ra, rb;
    skip_out_t r;
    f_l = longint'(f);
    x_l = longint'(x);
    g_l = longint'(g);
    a_w = (alpha_q > wrs_pkg::ALPHA_ONE) ? longint'(wrs_pkg::ALPHA_ONE) : longint'(alpha_q);
    b_w = longint'(wrs_pkg::ALPHA_ONE) - a_w;
    ra  = 0;
    rb  = 0;
    case (fn)
      wrs_pkg::FN_FWD: begin
        case (mode_q)
          wrs_pkg::MODE_PASS: ra = f_l;
          wrs_pkg::MODE_ADD:  ra = clamp_q88(f_l + x_l);
          wrs_pkg::MODE_MIX:  ra = clamp_q88(round_q15(a_w * f_l + b_w * x_l));
          default:            ra = 0;
        endcase
      end
      wrs_pkg::FN_BWD: begin
        case (mode_q)
          wrs_pkg::MODE_PASS: ra = g_l;
          wrs_pkg::MODE_ADD: begin
            ra = g_l;
            rb = g_l;
          end
          wrs_pkg::MODE_MIX: begin
            ra = clamp_q88(round_q15(g_l * a_w));
            rb = clamp_q88(round_q15(g_l * b_w));
            run_sum_q = acc_add_sat(run_sum_q, g_l * (f_l - x_l));
            if (last)
              grad_acc_q = acc_add_sat(grad_acc_q,
                                       round_q15(round_q15(run_sum_q * a_w) * b_w));
          end
          default: ;
        endcase
        if (last) run_sum_q = 0;
      end
      wrs_pkg::FN_CLR: begin
        grad_acc_q = 0;
        run_sum_q  = 0;
      end
      default: ;
    endcase
    r.out_a      = ra[15:0];
    r.out_b      = rb[15:0];
    r.grad_total = grad_acc_q[47:0];
    return r;
  endfunction

  always @(posedge clk) begin
    skip_out_t got, want;
    if (!rst_n) begin
      mode_q     = wrs_pkg::MODE_PASS;
      alpha_q    = wrs_pkg::ALPHA_RESET;
      run_sum_q  = 0;
      grad_acc_q = 0;
      expected_outs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_outs.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_outs.pop_front();
          if (got.out_a !== want.out_a) begin
            $error("out_a: expected %0d, got %0d", $signed(want.out_a), $signed(got.out_a));
            mismatch_count++;
          end
          if (got.out_b !== want.out_b) begin
            $error("out_b: expected %0d, got %0d", $signed(want.out_b), $signed(got.out_b));
            mismatch_count++;
          end
          if (got.grad_total !== want.grad_total) begin
            $error("grad_total: expected %0d, got %0d",
                   $signed(want.grad_total), $signed(got.grad_total));
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wrs_pkg::REG_MODE) mode_q = cfg_data[1:0];
        else alpha_q = cfg_data;
      end
      if (in_tvalid && in_tready)
        expected_outs.push_back(predict_skip(in_tuser, in_tdata[15:0], in_tdata[31:16],
                                             in_tdata[47:32], in_tlast));
    end
    open_results = expected_outs.size();
  end

endmodule

@@ sim/weighted_residual_skip_core_tb.sv @@
module weighted_residual_skip_core_tb;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_UNDEF  = 2'd3;
  localparam logic [1:0] FN_NONE     = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int mismatch_count;
  int open_results;
  int cycle_count = 0;
  int in_gap_max  = 11;
  int out_gap_max = 11;

  weighted_residual_skip_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  skip_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_residual_skip_core test failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each word.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [15:0] pick_q88();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 1023)) - 16'd512;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_word(input logic [1:0] fn, input logic [15:0] f,
                           input logic [15:0] x, input logic [15:0] g, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {g, x, f};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (open_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_skip_cfg(input logic [1:0] m, input logic [15:0] a);
    drain_results();
    write_reg(wrs_pkg::REG_MODE, {14'd0, m});
    write_reg(wrs_pkg::REG_ALPHA, a);
  endtask

  task automatic random_items(input int n);
    int done;
    int kind;
    int len;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // well-formed backward run closed by last
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          push_word(wrs_pkg::FN_BWD, pick_q88(), pick_q88(), pick_q88(), k == len - 1);
        done += len;
      end else if (kind < 83) begin
        push_word(wrs_pkg::FN_FWD, pick_q88(), pick_q88(), pick_q88(),
                  1'($urandom_range(0, 1)));
        done++;
      end else if (kind < 90) begin
        push_word(wrs_pkg::FN_BWD, pick_q88(), pick_q88(), pick_q88(), 1'b0);
        done++;
      end else if (kind < 95) begin
        push_word(wrs_pkg::FN_CLR, pick_q88(), pick_q88(), pick_q88(),
                  1'($urandom_range(0, 1)));
        done++;
      end else begin
        push_word(FN_NONE, pick_q88(), pick_q88(), pick_q88(), 1'($urandom_range(0, 1)));
        done++;
      end
    end
  endtask

  initial begin
    logic [1:0]  m;
    logic [15:0] a;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = wrs_pkg::FN_FWD;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = wrs_pkg::REG_MODE;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: pass mode, alpha one half
    push_word(wrs_pkg::FN_FWD, 16'h7fff, 16'h8000, 16'h0000, 1'b1);
    push_word(wrs_pkg::FN_FWD, 16'h8000, 16'h7fff, 16'hffff, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h1234, 16'h4321, 16'h8000, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    push_word(FN_NONE, 16'hffff, 16'hffff, 16'hffff, 1'b1);

    set_skip_cfg(wrs_pkg::MODE_ADD, wrs_pkg::ALPHA_RESET);
    push_word(wrs_pkg::FN_FWD, 16'h7fff, 16'h7fff, 16'h0001, 1'b0);
    push_word(wrs_pkg::FN_FWD, 16'h8000, 16'h8000, 16'h0001, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h0100, 16'h0200, 16'h8001, 1'b1);

    set_skip_cfg(wrs_pkg::MODE_MIX, 16'h8000);
    push_word(wrs_pkg::FN_FWD, 16'h7fff, 16'h8000, 16'h0000, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h7fff, 16'h8000, 16'h8000, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h7fff, 16'h8000, 16'h8000, 1'b1);

    set_skip_cfg(wrs_pkg::MODE_MIX, 16'h0000);
    push_word(wrs_pkg::FN_FWD, 16'h1234, 16'h8000, 16'h0000, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h8000, 16'h7fff, 16'h7fff, 1'b1);

    // alpha above one clamps to one
    set_skip_cfg(wrs_pkg::MODE_MIX, 16'hffff);
    push_word(wrs_pkg::FN_FWD, 16'h0a00, 16'hf600, 16'h0000, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h0a00, 16'hf600, 16'h0300, 1'b1);

    set_skip_cfg(wrs_pkg::MODE_MIX, wrs_pkg::ALPHA_RESET);
    push_word(wrs_pkg::FN_BWD, 16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
    push_word(wrs_pkg::FN_FWD, 16'h0001, 16'h0000, 16'h0000, 1'b0);
    push_word(wrs_pkg::FN_CLR, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h0200, 16'hfed4, 16'h0100, 1'b1);

    set_skip_cfg(MODE_UNDEF, 16'h4000);
    push_word(wrs_pkg::FN_FWD, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    push_word(wrs_pkg::FN_BWD, 16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    push_word(wrs_pkg::FN_CLR, 16'h0000, 16'h0000, 16'h0000, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: m = wrs_pkg::MODE_MIX;
        5, 6:          m = wrs_pkg::MODE_ADD;
        7, 8:          m = wrs_pkg::MODE_PASS;
        default:       m = MODE_UNDEF;
      endcase
      case ($urandom_range(0, 5))
        0:       a = 16'h0000;
        1:       a = 16'h8000;
        2:       a = 16'($urandom_range(32769, 65535));
        3:       a = wrs_pkg::ALPHA_RESET;
        default: a = 16'($urandom_range(1, 32767));
      endcase
      set_skip_cfg(m, a);
      random_items(43);
    end

    drain_results();
    repeat (30) @(negedge clk);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("weighted_residual_skip_core test passed");
    end else begin
      $display("weighted_residual_skip_core test failed");
    end
    $finish;
  end

endmodule

@@ weighted_residual_skip_core.f @@
rtl/core/wrs_pkg.sv
rtl/core/wrs_mac.sv
rtl/core/wrs_ctrl.sv
rtl/core/weighted_residual_skip_core.sv
sim/skip_result_checker.sv
sim/weighted_residual_skip_core_tb.sv
